[sv/thm_pkg.sv]
// ----------------------------------------------------------------------------
// thm_pkg
// Shared types, register indexes, class codes and defaults for the
// thermistor health monitor.
// ----------------------------------------------------------------------------
package thm_pkg;

	// default geometry
	localparam int unsigned SLAVES_DEFAULT  = 8;
	localparam int unsigned SENSORS_DEFAULT = 16;

	// field widths fixed by the transaction format
	localparam int unsigned VALUE_W   = 16;
	localparam int unsigned SLAVE_W   = 3;
	localparam int unsigned SENSOR_W  = 4;
	localparam int unsigned COUNT_W   = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_W     = 16;

	// broken tally saturation point
	localparam logic [COUNT_W-1:0] TALLY_MAX = 8'd128;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BROKEN_UPPER     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BROKEN_LOWER     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_UPPER      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOWER      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BROKEN_ALLOWANCE = 3'd4;

	// register reset values
	localparam logic [VALUE_W-1:0] BROKEN_UPPER_RST     = 16'd29000;
	localparam logic [VALUE_W-1:0] BROKEN_LOWER_RST     = 16'd1000;
	localparam logic [VALUE_W-1:0] LIMIT_UPPER_RST      = 16'd25000;
	localparam logic [VALUE_W-1:0] LIMIT_LOWER_RST      = 16'd5000;
	localparam logic [COUNT_W-1:0] BROKEN_ALLOWANCE_RST = 8'd0;

	// opcodes
	localparam logic OP_READING   = 1'b0;
	localparam logic OP_LOAD_MASK = 1'b1;

	// sensor classes
	localparam logic [1:0] CLASS_GOOD          = 2'd0;
	localparam logic [1:0] CLASS_OUT_OF_LIMITS = 2'd1;
	localparam logic [1:0] CLASS_BROKEN        = 2'd2;
	localparam logic [1:0] CLASS_NONE          = 2'd3;

	// input transaction
	typedef struct packed {
		logic                opcode;
		logic [SLAVE_W-1:0]  slave_index;
		logic [SENSOR_W-1:0] sensor_id;
		logic [VALUE_W-1:0]  value;
	} in_item_t;

	// result transaction
	typedef struct packed {
		logic [1:0]         sensor_class;
		logic               round_done;
		logic               round_ok;
		logic               fault;
		logic [COUNT_W-1:0] broken_count;
		logic               report_request;
	} out_item_t;

endpackage

[sv/thm_out_fifo.sv]
// ----------------------------------------------------------------------------
// thm_out_fifo
// Two-entry result queue that decouples the classifier from the consumer,
// so a new transaction is taken while a finished result is still waiting.
// ----------------------------------------------------------------------------
module thm_out_fifo
	import thm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_item,
	output logic      full,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	out_item_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	// occupancy flags
	assign full      = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && !out_stall;
	assign out_item  = entry_q[rd_ptr_q];

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_item;
	end

endmodule

[sv/thermistor_health_monitor_top.sv]
// ----------------------------------------------------------------------------
// thermistor_health_monitor_top
// Classifies thermistor readings against broken and limit bands, keeps the
// per-module cell and good masks, and closes a health round every
// SLAVES*SENSORS readings.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------
//   in      | input     | in_valid / in_stall    | in_item (in_item_t)
//   out     | output    | out_valid / out_stall  | out_item (out_item_t)
//   cfg     | input     | cfg_write              | cfg_index, cfg_data
//
// One transaction per cycle while in_stall is low; each result is registered
// into the result queue. State is updated in the accepting cycle, so the
// next reading sees it. A two-entry result queue holds results while
// out_stall is high; in_stall rises only when both entries are occupied.
// Reset clears masks, tally, round counter, fault and registers to defaults.
// ----------------------------------------------------------------------------
module thermistor_health_monitor_top
	import thm_pkg::*;
#(
	parameter int unsigned SLAVES  = SLAVES_DEFAULT,
	parameter int unsigned SENSORS = SENSORS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int unsigned ROUND_LEN = SLAVES * SENSORS;
	localparam int unsigned SW        = (SLAVES > 1) ? $clog2(SLAVES) : 1;
	localparam int unsigned CW        = $clog2(ROUND_LEN + 1);

	// configuration registers
	logic [VALUE_W-1:0] broken_upper_q;
	logic [VALUE_W-1:0] broken_lower_q;
	logic [VALUE_W-1:0] limit_upper_q;
	logic [VALUE_W-1:0] limit_lower_q;
	logic [COUNT_W-1:0] broken_allowance_q;

	// monitor state
	logic [SENSORS-1:0] cell_q [SLAVES];
	logic [SENSORS-1:0] good_q [SLAVES];
	logic [COUNT_W-1:0] tally_q;
	logic [CW-1:0]      round_q;
	logic               fault_q;

	// next-state and result logic
	logic               accept;
	logic               full;
	logic [SW-1:0]      idx;
	logic               slave_ok;
	logic               sensor_ok;
	logic [SENSORS-1:0] sel;
	logic [SENSORS-1:0] cell_cur;
	logic [SENSORS-1:0] good_cur;
	logic [SENSORS-1:0] cell_nx;
	logic [SENSORS-1:0] good_nx;
	logic [SENSORS-1:0] cell_d [SLAVES];
	logic [SENSORS-1:0] good_d [SLAVES];
	logic [COUNT_W-1:0] tally_nx;
	logic [CW-1:0]      round_nx;
	logic               fault_nx;
	logic               missing;
	out_item_t          res;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			broken_upper_q     <= BROKEN_UPPER_RST;
			broken_lower_q     <= BROKEN_LOWER_RST;
			limit_upper_q      <= LIMIT_UPPER_RST;
			limit_lower_q      <= LIMIT_LOWER_RST;
			broken_allowance_q <= BROKEN_ALLOWANCE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_BROKEN_UPPER:     broken_upper_q     <= cfg_data;
				REG_BROKEN_LOWER:     broken_lower_q     <= cfg_data;
				REG_LIMIT_UPPER:      limit_upper_q      <= cfg_data;
				REG_LIMIT_LOWER:      limit_lower_q      <= cfg_data;
				REG_BROKEN_ALLOWANCE: broken_allowance_q <= cfg_data[COUNT_W-1:0];
				default:              ;
			endcase
		end
	end

	// decode module and sensor
	assign idx       = in_item.slave_index[SW-1:0];
	assign slave_ok  = {1'b0, in_item.slave_index} < (SLAVE_W + 1)'(SLAVES);
	assign sensor_ok = {1'b0, in_item.sensor_id} < (SENSOR_W + 1)'(SENSORS);
	assign sel       = SENSORS'(1) << in_item.sensor_id;
	assign cell_cur  = cell_q[idx];
	assign good_cur  = good_q[idx];

	// classification and round bookkeeping
	always_comb begin
		cell_nx  = cell_cur;
		good_nx  = good_cur;
		tally_nx = tally_q;
		round_nx = round_q;
		fault_nx = fault_q;
		res                = '0;
		res.sensor_class   = CLASS_NONE;
		if (in_item.opcode == OP_LOAD_MASK) begin
			cell_nx = in_item.value[SENSORS-1:0];
		end else begin
			if (slave_ok && sensor_ok && ((cell_cur & sel) != '0)) begin
				if (in_item.value > broken_upper_q || in_item.value < broken_lower_q) begin
					res.sensor_class = CLASS_BROKEN;
					if (tally_q < TALLY_MAX) tally_nx = tally_q + 8'd1;
					cell_nx = cell_cur & ~sel;
					good_nx = good_cur & ~sel;
				end else if (in_item.value > limit_upper_q ||
				             in_item.value < limit_lower_q) begin
					res.sensor_class   = CLASS_OUT_OF_LIMITS;
					good_nx            = good_cur & ~sel;
					fault_nx           = 1'b1;
					res.report_request = 1'b1;
				end else begin
					res.sensor_class = CLASS_GOOD;
					good_nx          = good_cur | sel;
				end
			end
			round_nx = round_q + CW'(1);
		end
		for (int s = 0; s < SLAVES; s++) begin
			if (slave_ok && idx == SW'(s)) begin
				cell_d[s] = cell_nx;
				good_d[s] = good_nx;
			end else begin
				cell_d[s] = cell_q[s];
				good_d[s] = good_q[s];
			end
		end
		missing = 1'b0;
		for (int s = 0; s < SLAVES; s++) begin
			missing = missing | ((cell_d[s] & ~good_d[s]) != '0);
		end
		// close the round on its last reading
		if (in_item.opcode == OP_READING && round_q == CW'(ROUND_LEN - 1)) begin
			round_nx       = '0;
			res.round_done = 1'b1;
			if (tally_nx <= broken_allowance_q && !missing) begin
				res.round_ok = 1'b1;
				fault_nx     = 1'b0;
			end else begin
				fault_nx           = 1'b1;
				res.report_request = 1'b1;
			end
		end
		res.fault        = fault_nx;
		res.broken_count = tally_nx;
	end

	// state update on accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SLAVES; s++) begin
				cell_q[s] <= '0;
				good_q[s] <= '0;
			end
			tally_q <= '0;
			round_q <= '0;
			fault_q <= 1'b0;
		end else if (accept) begin
			for (int s = 0; s < SLAVES; s++) begin
				cell_q[s] <= cell_d[s];
				good_q[s] <= good_d[s];
			end
			tally_q <= tally_nx;
			round_q <= round_nx;
			fault_q <= fault_nx;
		end
	end

	// result queue
	thm_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_item (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

[sv/thm_checker.sv]
// ----------------------------------------------------------------------------
// thm_assert
// Port-level checks on the thermistor health monitor result channel,
// attached to the top level by bind.
// ----------------------------------------------------------------------------
module thm_assert
	import thm_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item
);

	// stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// stalled result does not change
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_item))
		else $error("result changed while stalled");

	// pass flag only with a closed round
	a_ok_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.round_done |-> !out_item.round_ok)
		else $error("round_ok without round_done");

	// failed round raises fault and report
	a_fail_reports: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.round_done && !out_item.round_ok
		|-> out_item.fault && out_item.report_request)
		else $error("failed round without fault and report");

	// out of limits reading raises fault and report
	a_limit_reports: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.sensor_class == CLASS_OUT_OF_LIMITS
		|-> out_item.fault && out_item.report_request)
		else $error("limit fault without fault and report");

endmodule

bind thermistor_health_monitor_top thm_assert u_thm_assert (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

[dv/thm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thm_checker
// Watches the input, result and register ports of the thermistor health
// monitor, keeps its own copy of the masks, tally, round position, fault flag
// and thresholds, and compares every result transaction with its prediction.
// ----------------------------------------------------------------------------
module thm_checker
	import thm_pkg::*;
#(
	parameter int unsigned SLAVES  = SLAVES_DEFAULT,
	parameter int unsigned SENSORS = SENSORS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  in_item_t             in_item,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  out_item_t            out_item,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int unsigned          results_due,
	output int unsigned          mismatch_count
);

	localparam logic [VALUE_W-1:0] SENSOR_BITS = VALUE_W'((32'd1 << SENSORS) - 1);
	localparam int unsigned        ROUND_LEN   = SLAVES * SENSORS;
	localparam int unsigned        PRINT_LIMIT = 100;

	// shadow thresholds
	logic [VALUE_W-1:0] brk_upper;
	logic [VALUE_W-1:0] brk_lower;
	logic [VALUE_W-1:0] lim_upper;
	logic [VALUE_W-1:0] lim_lower;
	logic [COUNT_W-1:0] allowance;

	// shadow health state
	logic [VALUE_W-1:0] cell_mask [SLAVES];
	logic [VALUE_W-1:0] good_mask [SLAVES];
	logic [COUNT_W-1:0] tally;
	int unsigned        readings_in_round;
	logic               fault;

	out_item_t health_results_due [$];

	// one line per mismatch, printing capped, counting not
	task automatic note_mismatch(input string what);
		if (mismatch_count < PRINT_LIMIT)
			$display("%0t ns  mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
		input logic [7:0] want);
		if (got !== want)
			note_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// round passes when the tally is within allowance and every cell sensor is good
	function automatic bit round_clean();
		bit clean;
		clean = (tally <= allowance);
		for (int unsigned s = 0; s < SLAVES; s++)
			if (((cell_mask[s] & SENSOR_BITS) & ~good_mask[s]) != '0)
				clean = 1'b0;
		return clean;
	endfunction

	// classify one transaction and advance the shadow state
	function automatic out_item_t health_result_for(input in_item_t it);
		out_item_t          res;
		logic [VALUE_W-1:0] sel;
		res = '0;
		res.sensor_class = CLASS_NONE;
		if (it.opcode == OP_LOAD_MASK) begin
			if (it.slave_index < SLAVES)
				cell_mask[it.slave_index] = it.value & SENSOR_BITS;
		end else begin
			if (it.slave_index < SLAVES && it.sensor_id < SENSORS) begin
				sel = VALUE_W'(1) << it.sensor_id;
				if ((cell_mask[it.slave_index] & sel) != '0) begin
					if (it.value > brk_upper || it.value < brk_lower) begin
						res.sensor_class = CLASS_BROKEN;
						if (tally < TALLY_MAX)
							tally++;
						cell_mask[it.slave_index] &= ~sel;
						good_mask[it.slave_index] &= ~sel;
					end else if (it.value > lim_upper || it.value < lim_lower) begin
						res.sensor_class = CLASS_OUT_OF_LIMITS;
						good_mask[it.slave_index] &= ~sel;
						fault = 1'b1;
						res.report_request = 1'b1;
					end else begin
						res.sensor_class = CLASS_GOOD;
						good_mask[it.slave_index] |= sel;
					end
				end
			end
			// every reading counts towards the round, classed or not
			readings_in_round++;
			if (readings_in_round >= ROUND_LEN) begin
				readings_in_round = 0;
				res.round_done = 1'b1;
				if (round_clean()) begin
					res.round_ok = 1'b1;
					fault = 1'b0;
				end else begin
					fault = 1'b1;
					res.report_request = 1'b1;
				end
			end
		end
		res.fault = fault;
		res.broken_count = tally;
		return res;
	endfunction

	// channel monitor: results first, then register writes, then inputs
	always @(posedge clk or negedge arst_n) begin : monitor
		out_item_t want;
		if (!arst_n) begin
			brk_upper = BROKEN_UPPER_RST;
			brk_lower = BROKEN_LOWER_RST;
			lim_upper = LIMIT_UPPER_RST;
			lim_lower = LIMIT_LOWER_RST;
			allowance = BROKEN_ALLOWANCE_RST;
			for (int unsigned s = 0; s < SLAVES; s++) begin
				cell_mask[s] = '0;
				good_mask[s] = '0;
			end
			tally = '0;
			readings_in_round = 0;
			fault = 1'b0;
			health_results_due.delete();
			mismatch_count = 0;
			results_due <= 0;
		end else begin
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (health_results_due.size() == 0) begin
					note_mismatch($sformatf("result %h with nothing expected", out_item));
				end else begin
					want = health_results_due.pop_front();
					check_field("sensor_class", out_item.sensor_class, want.sensor_class);
					check_field("round_done", out_item.round_done, want.round_done);
					check_field("round_ok", out_item.round_ok, want.round_ok);
					check_field("fault", out_item.fault, want.fault);
					check_field("broken_count", out_item.broken_count, want.broken_count);
					check_field("report_request", out_item.report_request,
						want.report_request);
				end
			end
			if (cfg_write === 1'b1) begin
				case (cfg_index)
					REG_BROKEN_UPPER:     brk_upper = cfg_data;
					REG_BROKEN_LOWER:     brk_lower = cfg_data;
					REG_LIMIT_UPPER:      lim_upper = cfg_data;
					REG_LIMIT_LOWER:      lim_lower = cfg_data;
					REG_BROKEN_ALLOWANCE: allowance = cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid === 1'b1 && in_stall === 1'b0)
				health_results_due.push_back(health_result_for(in_item));
			results_due <= health_results_due.size();
		end
	end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the thermistor health monitor: directed corner readings under
// the reset thresholds, then phases of scans, broken-sensor bursts and noise
// under extreme and random thresholds, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb
	import thm_pkg::*;
();

	localparam int unsigned        WATCHDOG_LIMIT = 5000;
	localparam int unsigned        SETTLE_CYCLES  = 4;
	localparam int unsigned        PHASES         = 8;
	localparam int unsigned        PHASE_ITEMS    = 170;
	localparam int unsigned        IN_ITEM_W      = $bits(in_item_t);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW = 3'd5;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	in_item_t             in_item   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_item;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	int unsigned          results_due;
	int unsigned          mismatch_count;

	// thresholds as last written, used to aim readings at the bands
	logic [VALUE_W-1:0] brk_hi = BROKEN_UPPER_RST;
	logic [VALUE_W-1:0] brk_lo = BROKEN_LOWER_RST;
	logic [VALUE_W-1:0] lim_hi = LIMIT_UPPER_RST;
	logic [VALUE_W-1:0] lim_lo = LIMIT_LOWER_RST;

	int unsigned calm_left  = 0;
	int unsigned stall_left = 0;
	int unsigned idle_cycles;

	thermistor_health_monitor_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	thm_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_item        (in_item),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_item       (out_item),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.results_due    (results_due),
		.mismatch_count (mismatch_count)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stall pattern: calm runs, short flickers, occasional long holds
	always @(posedge clk) begin : stall_gen
		int unsigned roll;
		if (arst_n) begin
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
			end else begin
				roll = $urandom_range(99);
				if (roll < 10) begin
					out_stall  <= 1'b0;
					stall_left <= $urandom_range(120, 30);
				end else if (roll < 70) begin
					out_stall  <= 1'b0;
					stall_left <= $urandom_range(4, 0);
				end else if (roll < 95) begin
					out_stall  <= 1'b1;
					stall_left <= $urandom_range(3, 0);
				end else begin
					out_stall  <= 1'b1;
					stall_left <= $urandom_range(60, 10);
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("thermistor_health_monitor_top verification failed");
		$finish;
	end

	// sender gap: mostly none, a few long, with calm stretches
	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (calm_left != 0) begin
			calm_left--;
			return 0;
		end
		roll = $urandom_range(99);
		if (roll < 3) begin
			calm_left = $urandom_range(80, 30);
			return 0;
		end
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(3, 1);
		if (roll < 98)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic in_item_t make_item(input logic op, input int unsigned slave,
		input int unsigned sensor, input logic [VALUE_W-1:0] val);
		in_item_t it;
		it.opcode      = op;
		it.slave_index = SLAVE_W'(slave);
		it.sensor_id   = SENSOR_W'(sensor);
		it.value       = val;
		return it;
	endfunction

	// readings mostly inside the good band, some on band edges, some anywhere
	function automatic logic [VALUE_W-1:0] pick_reading();
		int unsigned roll;
		int unsigned lo;
		int unsigned hi;
		roll = $urandom_range(99);
		lo = (brk_lo > lim_lo) ? brk_lo : lim_lo;
		hi = (brk_hi < lim_hi) ? brk_hi : lim_hi;
		if (roll < 65 && lo <= hi)
			return VALUE_W'($urandom_range(hi, lo));
		if (roll < 90) begin
			case ($urandom_range(9))
				0: return brk_hi;
				1: return brk_hi + VALUE_W'(1);
				2: return brk_lo;
				3: return brk_lo - VALUE_W'(1);
				4: return lim_hi;
				5: return lim_hi + VALUE_W'(1);
				6: return lim_lo;
				7: return lim_lo - VALUE_W'(1);
				8: return '0;
				default: return '1;
			endcase
		end
		return VALUE_W'($urandom());
	endfunction

	// a reading outside the broken band, if the band leaves room for one
	function automatic logic [VALUE_W-1:0] pick_broken();
		if (brk_hi != '1 && (brk_lo == '0 || $urandom_range(1) == 0))
			return VALUE_W'($urandom_range(16'hFFFF, int'(brk_hi) + 1));
		if (brk_lo != '0)
			return VALUE_W'($urandom_range(int'(brk_lo) - 1, 0));
		return VALUE_W'($urandom());
	endfunction

	function automatic logic [VALUE_W-1:0] pick_mask();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 50)
			return '1;
		if (roll < 62)
			return '0;
		if (roll < 80)
			return VALUE_W'($urandom() & $urandom() & $urandom());
		return VALUE_W'($urandom());
	endfunction

	// one input transaction, then an optional gap
	task automatic push_item(input in_item_t it);
		int unsigned gap;
		in_item  <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drop valid and wait until every predicted result has arrived
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// back-to-back register writes, one spare index among them
	task automatic program_registers(input logic [CFG_W-1:0] bu, input logic [CFG_W-1:0] bl,
		input logic [CFG_W-1:0] lu, input logic [CFG_W-1:0] ll,
		input logic [CFG_W-1:0] ba);
		logic [CFG_IDX_W-1:0] idx [6];
		logic [CFG_W-1:0]     dat [6];
		idx = '{REG_SPARE_LOW + CFG_IDX_W'($urandom_range(2)), REG_BROKEN_UPPER,
			REG_BROKEN_LOWER, REG_LIMIT_UPPER, REG_LIMIT_LOWER, REG_BROKEN_ALLOWANCE};
		dat = '{CFG_W'($urandom()), bu, bl, lu, ll, ba};
		for (int i = 0; i < 6; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= dat[i];
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		brk_hi = bu;
		brk_lo = bl;
		lim_hi = lu;
		lim_lo = ll;
	endtask

	// threshold sets: the extremes first, then random bands
	task automatic apply_settings(input int unsigned phase);
		logic [CFG_W-1:0] bl;
		logic [CFG_W-1:0] bu;
		case (phase)
			0: program_registers('0, '0, '0, '0, '0);
			1: program_registers('1, '1, '1, '1, '1);
			2: program_registers('1, '0, '1, '0, CFG_W'(TALLY_MAX));
			3: program_registers('0, '1, '0, '1, 16'hFF00);
			default: begin
				bl = CFG_W'($urandom_range(3000, 0));
				bu = CFG_W'($urandom_range(65535, 40000));
				program_registers(bu, bl, CFG_W'($urandom_range(39000, 20000)),
					CFG_W'($urandom_range(15000, bl)),
					($urandom_range(3) == 0) ? CFG_W'($urandom()) :
					CFG_W'($urandom_range(TALLY_MAX, 0)));
			end
		endcase
	endtask

	// corner readings under the reset thresholds
	task automatic run_directed();
		// no mask loaded yet
		push_item(make_item(OP_READING, 0, 0, 16'd12000));
		push_item(make_item(OP_LOAD_MASK, 0, 0, 16'hFFFF));
		push_item(make_item(OP_LOAD_MASK, 7, 15, 16'h8001));
		push_item(make_item(OP_LOAD_MASK, 3, 5, '0));
		// broken band and limit band edges
		push_item(make_item(OP_READING, 0, 0, '0));
		push_item(make_item(OP_READING, 0, 1, '1));
		push_item(make_item(OP_READING, 0, 2, BROKEN_UPPER_RST));
		push_item(make_item(OP_READING, 0, 3, BROKEN_UPPER_RST + 16'd1));
		push_item(make_item(OP_READING, 0, 4, BROKEN_LOWER_RST));
		push_item(make_item(OP_READING, 0, 5, BROKEN_LOWER_RST - 16'd1));
		push_item(make_item(OP_READING, 0, 6, LIMIT_UPPER_RST));
		push_item(make_item(OP_READING, 0, 7, LIMIT_UPPER_RST + 16'd1));
		push_item(make_item(OP_READING, 0, 8, LIMIT_LOWER_RST));
		push_item(make_item(OP_READING, 0, 9, LIMIT_LOWER_RST - 16'd1));
		push_item(make_item(OP_READING, 0, 15, 16'd12345));
		// edge sensors of a sparse mask, and one outside it
		push_item(make_item(OP_READING, 7, 15, 16'd15000));
		push_item(make_item(OP_READING, 7, 0, 16'd20000));
		push_item(make_item(OP_READING, 7, 1, 16'd15000));
		// sensor dropped from the mask after being broken
		push_item(make_item(OP_READING, 0, 0, 16'd15000));
		push_item(make_item(OP_READING, 3, 4, 16'd15000));
		// out-of-limits sensor recovering
		push_item(make_item(OP_READING, 0, 7, 16'd15000));
	endtask

	// random phase: full scans, broken bursts and noise
	task automatic run_phase(input int unsigned quota);
		int unsigned sent;
		int unsigned roll;
		int unsigned target;
		in_item_t    it;
		sent = 0;
		for (int unsigned s = 0; s < SLAVES_DEFAULT; s++) begin
			push_item(make_item(OP_LOAD_MASK, s, $urandom_range(15), pick_mask()));
			sent++;
		end
		while (sent < quota) begin
			roll = $urandom_range(99);
			if (roll < 55) begin
				// ordered scan, sometimes with fresh masks
				if ($urandom_range(1) == 0) begin
					for (int unsigned s = 0; s < SLAVES_DEFAULT; s++) begin
						push_item(make_item(OP_LOAD_MASK, s, $urandom_range(15), pick_mask()));
						sent++;
					end
				end
				for (int unsigned s = 0; s < SLAVES_DEFAULT; s++) begin
					for (int unsigned k = 0; k < SENSORS_DEFAULT; k++) begin
						push_item(make_item(OP_READING, s, k, pick_reading()));
						sent++;
					end
				end
			end else if (roll < 70) begin
				// one module turning broken sensor by sensor
				target = $urandom_range(SLAVES_DEFAULT - 1);
				push_item(make_item(OP_LOAD_MASK, target, $urandom_range(15), '1));
				sent++;
				for (int unsigned k = 0; k < SENSORS_DEFAULT; k++) begin
					push_item(make_item(OP_READING, target, k, pick_broken()));
					sent++;
				end
			end else begin
				// unordered noise
				for (int unsigned k = 0; k < 20; k++) begin
					it = in_item_t'(IN_ITEM_W'($urandom()));
					it.opcode = ($urandom_range(4) == 0) ? OP_LOAD_MASK : OP_READING;
					if (it.opcode == OP_READING && $urandom_range(1) == 0)
						it.value = pick_reading();
					push_item(it);
					sent++;
				end
			end
		end
	endtask

	// main sequence and verdict
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		wait_idle();
		for (int unsigned p = 0; p < PHASES; p++) begin
			apply_settings(p);
			run_phase(PHASE_ITEMS);
			wait_idle();
		end
		if (mismatch_count == 0 && results_due == 0)
			$display("thermistor_health_monitor_top verification clean");
		else
			$display("thermistor_health_monitor_top verification failed");
		$finish;
	end

endmodule

[thermistor_health_monitor_top.f]
sv/thm_pkg.sv
sv/thm_out_fifo.sv
sv/thermistor_health_monitor_top.sv
sv/thm_checker.sv
dv/thm_checker.sv
dv/tb.sv
